// File: hdl/csl_pkg.sv
// csl_pkg: shared types, token codes and character helpers for the subset lexer
// no dependencies; imported by every lexer module
package csl_pkg;

	// token text limits
	localparam int IDENT_MAX  = 32;
	localparam int STRING_MAX = 32;

	// text buffer geometry: two banks of 32 bytes
	localparam int TEXT_AW = 5;
	localparam int QDEPTH  = 4;

	localparam logic [23:0] LINE_MAX = 24'hFFFFFF;

	// token kinds
	localparam logic [5:0] K_EOF      = 6'd0;
	localparam logic [5:0] K_IDENT    = 6'd1;
	localparam logic [5:0] K_NUM      = 6'd2;
	localparam logic [5:0] K_STR      = 6'd3;
	localparam logic [5:0] K_CHAR     = 6'd4;
	localparam logic [5:0] K_INT      = 6'd5;
	localparam logic [5:0] K_CHARKW   = 6'd6;
	localparam logic [5:0] K_VOID     = 6'd7;
	localparam logic [5:0] K_IF       = 6'd8;
	localparam logic [5:0] K_ELSE     = 6'd9;
	localparam logic [5:0] K_WHILE    = 6'd10;
	localparam logic [5:0] K_FOR      = 6'd11;
	localparam logic [5:0] K_RETURN   = 6'd12;
	localparam logic [5:0] K_ASM      = 6'd13;
	localparam logic [5:0] K_BREAK    = 6'd14;
	localparam logic [5:0] K_CONTINUE = 6'd15;
	localparam logic [5:0] K_PLUS     = 6'd16;
	localparam logic [5:0] K_INC      = 6'd17;
	localparam logic [5:0] K_ADDEQ    = 6'd18;
	localparam logic [5:0] K_MINUS    = 6'd19;
	localparam logic [5:0] K_DEC      = 6'd20;
	localparam logic [5:0] K_SUBEQ    = 6'd21;
	localparam logic [5:0] K_STAR     = 6'd22;
	localparam logic [5:0] K_MULEQ    = 6'd23;
	localparam logic [5:0] K_SLASH    = 6'd24;
	localparam logic [5:0] K_DIVEQ    = 6'd25;
	localparam logic [5:0] K_PCT      = 6'd26;
	localparam logic [5:0] K_ASSIGN   = 6'd27;
	localparam logic [5:0] K_EQ       = 6'd28;
	localparam logic [5:0] K_NOT      = 6'd29;
	localparam logic [5:0] K_NE       = 6'd30;
	localparam logic [5:0] K_LT       = 6'd31;
	localparam logic [5:0] K_LE       = 6'd32;
	localparam logic [5:0] K_SHL      = 6'd33;
	localparam logic [5:0] K_GT       = 6'd34;
	localparam logic [5:0] K_GE       = 6'd35;
	localparam logic [5:0] K_SHR      = 6'd36;
	localparam logic [5:0] K_AMP      = 6'd37;
	localparam logic [5:0] K_LAND     = 6'd38;
	localparam logic [5:0] K_BAR      = 6'd39;
	localparam logic [5:0] K_LOR      = 6'd40;
	localparam logic [5:0] K_CARET    = 6'd41;
	localparam logic [5:0] K_TILDE    = 6'd42;
	localparam logic [5:0] K_LPAREN   = 6'd43;
	localparam logic [5:0] K_RPAREN   = 6'd44;
	localparam logic [5:0] K_LBRACE   = 6'd45;
	localparam logic [5:0] K_RBRACE   = 6'd46;
	localparam logic [5:0] K_LBRACK   = 6'd47;
	localparam logic [5:0] K_RBRACK   = 6'd48;
	localparam logic [5:0] K_SEMI     = 6'd49;
	localparam logic [5:0] K_COMMA    = 6'd50;
	localparam logic [5:0] K_ERR      = 6'd51;

	typedef struct packed {
		logic [7:0] char_byte;
		logic       source_end;
	} in_item_t;

	typedef struct packed {
		logic [5:0]         token_kind;
		logic [7:0]         text_byte;
		logic               text_valid;
		logic signed [31:0] token_value;
		logic [23:0]        token_line;
		logic               token_end;
		logic               last;
	} out_item_t;

	// one finished token handed from scanner to emitter
	typedef struct packed {
		logic [5:0]  kind;
		logic [31:0] value;
		logic [23:0] line;
		logic [5:0]  cnt;
		logic        from_store;
		logic        bank;
		logic [7:0]  b0;
		logic [7:0]  b1;
		logic        last;
	} cmd_t;

	// text buffer write port
	typedef struct packed {
		logic                 en;
		logic [TEXT_AW:0]     addr;
		logic [7:0]           data;
	} mem_wr_t;

	// bank release from emitter
	typedef struct packed {
		logic done;
		logic bank;
	} rel_t;

	function automatic cmd_t mk_cmd(input logic [5:0] kind, input logic [31:0] value,
			input logic [23:0] line, input logic [5:0] cnt, input logic from_store,
			input logic bank, input logic [7:0] b0, input logic [7:0] b1);
		cmd_t r;
		r.kind       = kind;
		r.value      = value;
		r.line       = line;
		r.cnt        = cnt;
		r.from_store = from_store;
		r.bank       = bank;
		r.b0         = b0;
		r.b1         = b1;
		r.last       = 1'b0;
		return r;
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	// msb set when the byte is a hex digit
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [7:0] d;
		d = 8'd0;
		if (c >= "0" && c <= "9") begin
			d = c - 8'h30;
			return {1'b1, d[3:0]};
		end else if (c >= "a" && c <= "f") begin
			d = c - 8'h57;
			return {1'b1, d[3:0]};
		end else if (c >= "A" && c <= "F") begin
			d = c - 8'h37;
			return {1'b1, d[3:0]};
		end
		return 5'd0;
	endfunction

	function automatic logic [7:0] escape_of(input logic [7:0] c);
		case (c)
			"n": return 8'd10;
			"t": return 8'd9;
			"r": return 8'd13;
			"0": return 8'd0;
			default: return c;
		endcase
	endfunction

	// operator code for a pair, second byte zero for a single; zero when none
	function automatic logic [5:0] op_kind(input logic [7:0] a, input logic [7:0] b);
		case ({a, b})
			{"+", 8'd0}: return K_PLUS;
			"++":        return K_INC;
			"+=":        return K_ADDEQ;
			{"-", 8'd0}: return K_MINUS;
			"--":        return K_DEC;
			"-=":        return K_SUBEQ;
			{"*", 8'd0}: return K_STAR;
			"*=":        return K_MULEQ;
			{"/", 8'd0}: return K_SLASH;
			"/=":        return K_DIVEQ;
			{"%", 8'd0}: return K_PCT;
			{"=", 8'd0}: return K_ASSIGN;
			"==":        return K_EQ;
			{"!", 8'd0}: return K_NOT;
			"!=":        return K_NE;
			{"<", 8'd0}: return K_LT;
			"<=":        return K_LE;
			"<<":        return K_SHL;
			{">", 8'd0}: return K_GT;
			">=":        return K_GE;
			">>":        return K_SHR;
			{"&", 8'd0}: return K_AMP;
			"&&":        return K_LAND;
			{"|", 8'd0}: return K_BAR;
			"||":        return K_LOR;
			{"^", 8'd0}: return K_CARET;
			{"~", 8'd0}: return K_TILDE;
			{"(", 8'd0}: return K_LPAREN;
			{")", 8'd0}: return K_RPAREN;
			{"{", 8'd0}: return K_LBRACE;
			{"}", 8'd0}: return K_RBRACE;
			{"[", 8'd0}: return K_LBRACK;
			{"]", 8'd0}: return K_RBRACK;
			{";", 8'd0}: return K_SEMI;
			{",", 8'd0}: return K_COMMA;
			default:     return K_EOF;
		endcase
	endfunction

	// first byte of some two-byte operator
	function automatic logic can_pair(input logic [7:0] a);
		return a == "+" || a == "-" || a == "*" || a == "/" || a == "=" ||
			a == "!" || a == "<" || a == ">" || a == "&" || a == "|";
	endfunction

	// keyword match on up to eight bytes, newest byte lowest
	function automatic logic [5:0] kw_kind(input logic [63:0] kb, input logic [5:0] n);
		logic [5:0] k;
		k = K_IDENT;
		case (n)
			6'd2: if (kb[15:0] == "if") k = K_IF;
			6'd3: begin
				if (kb[23:0] == "int") k = K_INT;
				else if (kb[23:0] == "for") k = K_FOR;
				else if (kb[23:0] == "asm") k = K_ASM;
			end
			6'd4: begin
				if (kb[31:0] == "char") k = K_CHARKW;
				else if (kb[31:0] == "void") k = K_VOID;
				else if (kb[31:0] == "else") k = K_ELSE;
			end
			6'd5: begin
				if (kb[39:0] == "while") k = K_WHILE;
				else if (kb[39:0] == "break") k = K_BREAK;
			end
			6'd6: if (kb[47:0] == "return") k = K_RETURN;
			6'd8: if (kb[63:0] == "continue") k = K_CONTINUE;
			default: k = K_IDENT;
		endcase
		return k;
	endfunction

endpackage

// File: hdl/csl_front.sv
// csl_front: byte scanner; classifies source bytes and hands finished tokens on
// depends on csl_pkg; feeds csl_queue and the text buffer in csl_back
module csl_front import csl_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     src_valid,
	output logic     src_stall,
	input  in_item_t src_item,
	input  logic [2:0] q_fill,
	output logic     push_a,
	output logic     push_b,
	output cmd_t     cmd_a,
	output cmd_t     cmd_b,
	output mem_wr_t  mem_wr,
	input  rel_t     rel
);

	localparam logic [3:0] M_IDLE    = 4'd0;
	localparam logic [3:0] M_LINEC   = 4'd1;
	localparam logic [3:0] M_BLOCK   = 4'd2;
	localparam logic [3:0] M_BSTAR   = 4'd3;
	localparam logic [3:0] M_IDENT   = 4'd4;
	localparam logic [3:0] M_ZERO    = 4'd5;
	localparam logic [3:0] M_DEC     = 4'd6;
	localparam logic [3:0] M_HEX     = 4'd7;
	localparam logic [3:0] M_STR     = 4'd8;
	localparam logic [3:0] M_STRESC  = 4'd9;
	localparam logic [3:0] M_CHOPEN  = 4'd10;
	localparam logic [3:0] M_CHESC   = 4'd11;
	localparam logic [3:0] M_CHCLOSE = 4'd12;
	localparam logic [3:0] M_OP      = 4'd13;
	localparam logic [3:0] M_SLASH   = 4'd14;

	localparam logic [5:0] ID_LIM  = 6'(IDENT_MAX - 1);
	localparam logic [5:0] STR_LIM = 6'(STRING_MAX - 1);

	logic [3:0]  mode_q, mode_n;
	logic [5:0]  cnt_q, cnt_n;
	logic [31:0] val_q, val_n;
	logic [23:0] line_q, line_n;
	logic [23:0] sline_q, sline_n;
	logic [7:0]  held_q, held_n;
	logic [63:0] kw_q, kw_n;
	logic        bank_q, bank_n;
	logic [1:0]  busy_q, busy_n;

	logic        take;
	logic        again;
	logic [7:0]  c;
	logic [4:0]  hx;
	logic [5:0]  pk;
	cmd_t        e;

	assign c    = src_item.char_byte;
	assign hx   = hex_digit(c);
	assign pk   = op_kind(held_q, c);
	assign take = src_valid && !src_stall;

	// room for two tokens and a free bank for the next one
	assign src_stall = (q_fill > 3'(QDEPTH - 2)) || busy_q[~bank_q];

	// scan one byte: flush on source end, else a first pass in the current mode and, if needed, a restart from idle
	always_comb begin
		mode_n  = mode_q;
		cnt_n   = cnt_q;
		val_n   = val_q;
		line_n  = line_q;
		sline_n = sline_q;
		held_n  = held_q;
		kw_n    = kw_q;
		bank_n  = bank_q;
		push_a  = 1'b0;
		push_b  = 1'b0;
		cmd_a   = '0;
		cmd_b   = '0;
		mem_wr  = '0;
		again   = 1'b0;
		e       = '0;
		if (take) begin
			if (src_item.source_end || c == 8'd0) begin
				// flush the pending token
				case (mode_q)
					M_IDENT: begin
						cmd_a  = mk_cmd(kw_kind(kw_q, cnt_q), 32'd0, sline_q, cnt_q, 1'b1,
							bank_q, 8'd0, 8'd0);
						push_a = 1'b1;
					end
					M_ZERO, M_DEC, M_HEX: begin
						cmd_a  = mk_cmd(K_NUM, val_q, sline_q, cnt_q, 1'b1, bank_q, 8'd0, 8'd0);
						push_a = 1'b1;
					end
					M_STRESC: begin
						mem_wr.en   = 1'b1;
						mem_wr.addr = {bank_q, cnt_q[TEXT_AW-1:0]};
						mem_wr.data = 8'd0;
						cmd_a  = mk_cmd(K_STR, 32'(cnt_q + 6'd1), sline_q, cnt_q + 6'd1, 1'b1,
							bank_q, 8'd0, 8'd0);
						push_a = 1'b1;
					end
					M_STR: begin
						cmd_a  = mk_cmd(K_STR, 32'(cnt_q), sline_q, cnt_q, 1'b1, bank_q,
							8'd0, 8'd0);
						push_a = 1'b1;
					end
					M_CHOPEN, M_CHESC: begin
						cmd_a  = mk_cmd(K_CHAR, 32'd0, sline_q, 6'd1, 1'b0, bank_q, 8'd0, 8'd0);
						push_a = 1'b1;
					end
					M_CHCLOSE: begin
						cmd_a  = mk_cmd(K_CHAR, val_q, sline_q, 6'd1, 1'b0, bank_q, val_q[7:0],
							8'd0);
						push_a = 1'b1;
					end
					M_SLASH, M_OP: begin
						cmd_a  = mk_cmd(op_kind(held_q, 8'd0), 32'd0, sline_q, 6'd1, 1'b0,
							bank_q, held_q, 8'd0);
						push_a = 1'b1;
					end
					default: ;
				endcase
				// end of source marker
				e = mk_cmd(K_EOF, 32'd0, line_q, 6'd0, 1'b0, bank_q, 8'd0, 8'd0);
				if (push_a) begin
					cmd_b  = e;
					push_b = 1'b1;
				end else begin
					cmd_a  = e;
					push_a = 1'b1;
				end
				if (push_a && cmd_a.from_store) bank_n = ~bank_q;
				mode_n  = M_IDLE;
				cnt_n   = 6'd0;
				val_n   = 32'd0;
				line_n  = 24'd1;
				sline_n = 24'd1;
				held_n  = 8'd0;
			end else begin
				case (mode_q)
					M_IDLE: again = 1'b1;
					M_LINEC: if (c == 8'h0A) mode_n = M_IDLE;
					M_BLOCK: if (c == "*") mode_n = M_BSTAR;
					M_BSTAR: begin
						if (c == "/") mode_n = M_IDLE;
						else if (c != "*") mode_n = M_BLOCK;
					end
					M_IDENT: begin
						if ((is_alpha(c) || is_digit(c)) && cnt_q < ID_LIM) begin
							mem_wr.en   = 1'b1;
							mem_wr.addr = {bank_q, cnt_q[TEXT_AW-1:0]};
							mem_wr.data = c;
							if (cnt_q < 6'd8) kw_n = {kw_q[55:0], c};
							cnt_n = cnt_q + 6'd1;
						end else begin
							cmd_a  = mk_cmd(kw_kind(kw_q, cnt_q), 32'd0, sline_q, cnt_q, 1'b1,
								bank_q, 8'd0, 8'd0);
							push_a = 1'b1;
							again  = 1'b1;
						end
					end
					M_ZERO, M_DEC: begin
						if (mode_q == M_ZERO && c == "x") begin
							mem_wr.en   = 1'b1;
							mem_wr.addr = {bank_q, cnt_q[TEXT_AW-1:0]};
							mem_wr.data = c;
							cnt_n  = cnt_q + 6'd1;
							val_n  = 32'd0;
							mode_n = M_HEX;
						end else if (is_digit(c) && cnt_q < ID_LIM) begin
							mem_wr.en   = 1'b1;
							mem_wr.addr = {bank_q, cnt_q[TEXT_AW-1:0]};
							mem_wr.data = c;
							cnt_n  = cnt_q + 6'd1;
							val_n  = (val_q << 3) + (val_q << 1) + 32'(c[3:0]);
							mode_n = M_DEC;
						end else begin
							cmd_a  = mk_cmd(K_NUM, val_q, sline_q, cnt_q, 1'b1, bank_q,
								8'd0, 8'd0);
							push_a = 1'b1;
							again  = 1'b1;
						end
					end
					M_HEX: begin
						if (hx[4] && cnt_q < ID_LIM) begin
							mem_wr.en   = 1'b1;
							mem_wr.addr = {bank_q, cnt_q[TEXT_AW-1:0]};
							mem_wr.data = c;
							cnt_n = cnt_q + 6'd1;
							val_n = {val_q[27:0], hx[3:0]};
						end else begin
							cmd_a  = mk_cmd(K_NUM, val_q, sline_q, cnt_q, 1'b1, bank_q,
								8'd0, 8'd0);
							push_a = 1'b1;
							again  = 1'b1;
						end
					end
					M_STR: begin
						if (cnt_q >= STR_LIM || c == "\"") begin
							cmd_a  = mk_cmd(K_STR, 32'(cnt_q), sline_q, cnt_q, 1'b1, bank_q,
								8'd0, 8'd0);
							push_a = 1'b1;
							mode_n = M_IDLE;
							again  = (c != "\"");
						end else if (c == "\\") begin
							mode_n = M_STRESC;
						end else begin
							mem_wr.en   = 1'b1;
							mem_wr.addr = {bank_q, cnt_q[TEXT_AW-1:0]};
							mem_wr.data = c;
							cnt_n = cnt_q + 6'd1;
						end
					end
					M_STRESC: begin
						mem_wr.en   = 1'b1;
						mem_wr.addr = {bank_q, cnt_q[TEXT_AW-1:0]};
						mem_wr.data = escape_of(c);
						cnt_n  = cnt_q + 6'd1;
						mode_n = M_STR;
					end
					M_CHOPEN: begin
						if (c == "\\") begin
							mode_n = M_CHESC;
						end else begin
							val_n  = 32'(c);
							mode_n = M_CHCLOSE;
						end
					end
					M_CHESC: begin
						val_n  = 32'(escape_of(c));
						mode_n = M_CHCLOSE;
					end
					M_CHCLOSE: begin
						cmd_a  = mk_cmd(K_CHAR, val_q, sline_q, 6'd1, 1'b0, bank_q, val_q[7:0],
							8'd0);
						push_a = 1'b1;
						mode_n = M_IDLE;
						again  = (c != "'");
					end
					M_SLASH, M_OP: begin
						if (mode_q == M_SLASH && c == "/") begin
							mode_n = M_LINEC;
						end else if (mode_q == M_SLASH && c == "*") begin
							mode_n = M_BLOCK;
						end else if (pk != K_EOF) begin
							cmd_a  = mk_cmd(pk, 32'd0, sline_q, 6'd2, 1'b0, bank_q, held_q, c);
							push_a = 1'b1;
							mode_n = M_IDLE;
						end else begin
							cmd_a  = mk_cmd(op_kind(held_q, 8'd0), 32'd0, sline_q, 6'd1, 1'b0,
								bank_q, held_q, 8'd0);
							push_a = 1'b1;
							again  = 1'b1;
						end
					end
					default: again = 1'b1;
				endcase
				if (push_a) begin
					cnt_n  = 6'd0;
					val_n  = 32'd0;
					mode_n = M_IDLE;
					if (cmd_a.from_store) bank_n = ~bank_q;
				end
				// restart from idle with the same byte
				if (again) begin
					mode_n = M_IDLE;
					if (!(c == " " || c == 8'h09 || c == 8'h0D || c == 8'h0A)) begin
						sline_n = line_q;
						cnt_n   = 6'd0;
						val_n   = 32'd0;
						if (is_alpha(c) || is_digit(c)) begin
							mem_wr.en   = 1'b1;
							mem_wr.addr = {bank_n, {TEXT_AW{1'b0}}};
							mem_wr.data = c;
							cnt_n = 6'd1;
							kw_n  = {56'd0, c};
							if (is_alpha(c)) mode_n = M_IDENT;
							else begin
								val_n  = 32'(c[3:0]);
								mode_n = (c == "0") ? M_ZERO : M_DEC;
							end
						end else if (c == "\"") begin
							mode_n = M_STR;
						end else if (c == "'") begin
							mode_n = M_CHOPEN;
						end else if (c == "/") begin
							held_n = c;
							mode_n = M_SLASH;
						end else if (can_pair(c)) begin
							held_n = c;
							mode_n = M_OP;
						end else begin
							e = mk_cmd((op_kind(c, 8'd0) != K_EOF) ? op_kind(c, 8'd0) : K_ERR,
								32'd0, line_q, 6'd1, 1'b0, bank_n, c, 8'd0);
							if (push_a) begin
								cmd_b  = e;
								push_b = 1'b1;
							end else begin
								cmd_a  = e;
								push_a = 1'b1;
							end
						end
					end
				end
				// count lines, saturating
				if (c == 8'h0A && line_q != LINE_MAX) line_n = line_q + 24'd1;
			end
			// final result of this byte
			if (push_a) cmd_a.last = !push_b;
			if (push_b) cmd_b.last = 1'b1;
		end
	end

	// bank ownership: set when a stored token is queued, cleared when emitted
	always_comb begin
		busy_n = busy_q;
		if (rel.done) busy_n[rel.bank] = 1'b0;
		if (push_a && cmd_a.from_store) busy_n[cmd_a.bank] = 1'b1;
	end

	// scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			cnt_q   <= 6'd0;
			val_q   <= 32'd0;
			line_q  <= 24'd1;
			sline_q <= 24'd1;
			held_q  <= 8'd0;
			bank_q  <= 1'b0;
			busy_q  <= 2'b00;
		end else begin
			mode_q  <= mode_n;
			cnt_q   <= cnt_n;
			val_q   <= val_n;
			line_q  <= line_n;
			sline_q <= sline_n;
			held_q  <= held_n;
			bank_q  <= bank_n;
			busy_q  <= busy_n;
		end
	end

	// keyword window, no reset needed
	always_ff @(posedge clk) begin
		kw_q <= kw_n;
	end

	// text writes never land in a bank still being emitted
	a_wr_free_bank: assert property (@(posedge clk) disable iff (!arst_n)
		mem_wr.en |-> !busy_q[mem_wr.addr[TEXT_AW]])
		else $error("text write into busy bank");

	// the bank being filled is never owned by the emitter
	a_cur_bank_free: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q[bank_q])
		else $error("scanner bank is busy");

	// line numbers start at one and saturate, never zero
	a_line_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		line_q != 24'd0 && sline_q != 24'd0)
		else $error("line number is zero");

endmodule

// File: hdl/csl_queue.sv
// csl_queue: short token queue between scanner and emitter, two pushes per cycle
// depends on csl_pkg for cmd_t and QDEPTH
module csl_queue import csl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push_a,
	input  logic       push_b,
	input  cmd_t       cmd_a,
	input  cmd_t       cmd_b,
	input  logic       pop,
	output cmd_t       head,
	output logic [2:0] fill
);

	localparam int PW = $clog2(QDEPTH);

	cmd_t            ent_q [QDEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [2:0]      fill_q;

	assign head = ent_q[rd_ptr_q];
	assign fill = fill_q;

	// entry storage
	always_ff @(posedge clk) begin
		if (push_a) ent_q[wr_ptr_q] <= cmd_a;
		if (push_b) ent_q[wr_ptr_q + PW'(1)] <= cmd_b;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= 3'd0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PW'(push_a) + PW'(push_b);
			rd_ptr_q <= rd_ptr_q + PW'(pop);
			fill_q   <= fill_q + 3'(push_a) + 3'(push_b) - 3'(pop);
		end
	end

	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		push_b |-> push_a)
		else $error("second push without first");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= 3'(QDEPTH) && !(pop && fill_q == 3'd0))
		else $error("queue overflow or underflow");

	// pointer distance agrees with the fill level
	a_fill_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		PW'(wr_ptr_q - rd_ptr_q) == fill_q[PW-1:0])
		else $error("queue pointers and fill disagree");

endmodule

// File: hdl/csl_back.sv
// csl_back: token emitter; owns the banked text buffer and drives result items
// depends on csl_pkg; takes tokens from csl_queue
module csl_back import csl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  mem_wr_t    mem_wr,
	input  cmd_t       head,
	input  logic [2:0] fill,
	output logic       pop,
	output rel_t       rel,
	output logic       tok_valid,
	input  logic       tok_stall,
	output out_item_t  tok_item
);

	localparam logic [1:0] B_IDLE = 2'd0;
	localparam logic [1:0] B_READ = 2'd1;
	localparam logic [1:0] B_OUT  = 2'd2;

	logic [7:0]         text_mem [2**(TEXT_AW+1)];
	logic [7:0]         rd_q;
	logic [1:0]         state_q;
	cmd_t               cur_q;
	logic [TEXT_AW-1:0] idx_q;
	logic               out_valid_q;
	out_item_t          out_q;
	logic               slot_free;
	logic               is_end;
	logic               load;
	out_item_t          nxt;

	assign slot_free = !out_valid_q || !tok_stall;
	assign is_end    = (cur_q.cnt == 6'd0) || ({1'b0, idx_q} + 6'd1 == cur_q.cnt);
	assign load      = (state_q == B_OUT) && slot_free;
	assign pop       = (state_q == B_IDLE) && (fill != 3'd0);
	assign rel.done  = load && is_end && cur_q.from_store;
	assign rel.bank  = cur_q.bank;
	assign tok_valid = out_valid_q;
	assign tok_item  = out_q;

	// next result item
	always_comb begin
		nxt.token_kind  = cur_q.kind;
		nxt.text_valid  = (cur_q.cnt != 6'd0);
		nxt.token_value = cur_q.value;
		nxt.token_line  = cur_q.line;
		nxt.token_end   = is_end;
		nxt.last        = is_end && cur_q.last;
		if (cur_q.cnt == 6'd0) nxt.text_byte = 8'd0;
		else if (cur_q.from_store) nxt.text_byte = rd_q;
		else if (idx_q == '0) nxt.text_byte = cur_q.b0;
		else nxt.text_byte = cur_q.b1;
	end

	// text buffer, registered read
	always_ff @(posedge clk) begin
		if (mem_wr.en) text_mem[mem_wr.addr] <= mem_wr.data;
		rd_q <= text_mem[{cur_q.bank, idx_q}];
	end

	// emitter sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// output slot: filled on load, kept while stalled
			out_valid_q <= load || (out_valid_q && tok_stall);
			case (state_q)
				B_IDLE: begin
					if (pop) begin
						idx_q   <= '0;
						state_q <= B_READ;
					end
				end
				B_READ: state_q <= B_OUT;
				B_OUT: begin
					if (slot_free) begin
						if (is_end) state_q <= B_IDLE;
						else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= B_READ;
						end
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (pop) cur_q <= head;
		if (load) out_q <= nxt;
	end

	// a token with no text is a single closing item with a zero byte
	a_empty_text: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.text_valid) |-> (out_q.token_end && out_q.text_byte == 8'd0))
		else $error("empty token not closed");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.last) |-> out_q.token_end)
		else $error("last item inside a token");

	// a stalled item stays valid and unchanged
	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && tok_stall) |=> (out_valid_q && $stable(out_q)))
		else $error("stalled item changed");

endmodule

// File: hdl/c_subset_lexer_top.sv
// c_subset_lexer_top: streaming lexer for a small C subset
// depends on csl_pkg, csl_front, csl_queue, csl_back
//
// Usage:
//   src channel: one source byte per item (char_byte, source_end). A set
//   source_end or a zero byte ends the source: the pending token is flushed,
//   an eof token follows and line counting restarts at 1.
//   tok channel: one item per token text byte; token_end marks the final
//   byte of a token, last the final item caused by one source item. Tokens
//   with empty text (eof, empty string) are a single item with text_valid 0.
// Flow:
//   the scanner takes one byte per cycle unless stalled and queues finished
//   tokens; the emitter reads the banked text buffer with a registered port,
//   stepping through a read state and an output state for each text byte,
//   and pops another token only after the last item of the current one.
//   The scanner stalls when the queue has fewer than two free slots or when
//   the text bank it would switch to is still being emitted.
// Reset: asynchronous, clears scanner mode, line count to 1, queue and
//   output valid. The text buffer is not cleared and needs no sweep.
// Receiver stall: the output register holds its item; the emitter, then
//   the queue and finally src_stall back up in turn.
module c_subset_lexer_top import csl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      src_valid,
	output logic      src_stall,
	input  in_item_t  src_item,
	output logic      tok_valid,
	input  logic      tok_stall,
	output out_item_t tok_item
);

	logic       push_a;
	logic       push_b;
	cmd_t       cmd_a;
	cmd_t       cmd_b;
	cmd_t       head;
	logic [2:0] fill;
	logic       pop;
	mem_wr_t    mem_wr;
	rel_t       rel;

	// scanner
	csl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_item  (src_item),
		.q_fill    (fill),
		.push_a    (push_a),
		.push_b    (push_b),
		.cmd_a     (cmd_a),
		.cmd_b     (cmd_b),
		.mem_wr    (mem_wr),
		.rel       (rel)
	);

	// token queue
	csl_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push_a (push_a),
		.push_b (push_b),
		.cmd_a  (cmd_a),
		.cmd_b  (cmd_b),
		.pop    (pop),
		.head   (head),
		.fill   (fill)
	);

	// emitter
	csl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mem_wr    (mem_wr),
		.head      (head),
		.fill      (fill),
		.pop       (pop),
		.rel       (rel),
		.tok_valid (tok_valid),
		.tok_stall (tok_stall),
		.tok_item  (tok_item)
	);

endmodule
